FILE: src/friction_circle_current_limit_defines.svh
// Assertion macros used by the checker file of the friction circle current limit.
`ifndef FRICTION_CIRCLE_CURRENT_LIMIT_DEFINES_SVH
`define FRICTION_CIRCLE_CURRENT_LIMIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FCCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FCCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/fccl_pkg.sv
// Shared widths, constants, register codes and types of the friction circle current limit.
`timescale 1ns / 1ps
package fccl_pkg;

	localparam int unsigned LOAD_W     = 16;
	localparam int unsigned ACCEL_W    = 16;
	localparam int unsigned LIMIT_W    = 16;
	localparam int unsigned MU_W       = 16;
	localparam int unsigned MASS_W     = 10;
	localparam int unsigned SHARE_W    = 17;
	localparam int unsigned CPF_W      = 20;
	localparam int unsigned CFG_W      = 20;
	localparam int unsigned FORCE_W    = 32;
	localparam int unsigned SQ_W       = 64;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned FY_SHIFT   = 9;
	localparam int unsigned CUR_SHIFT  = 28;

	localparam logic [SHARE_W-1:0] SHARE_ONE = 17'd65536;

	localparam logic [MU_W-1:0]    FRICTION_COEFF_RST    = 16'd16384;
	localparam logic [MASS_W-1:0]  VEHICLE_MASS_RST      = 10'd300;
	localparam logic [SHARE_W-1:0] REAR_WEIGHT_SHARE_RST = 17'd32768;
	localparam logic [CPF_W-1:0]   CURRENT_PER_FORCE_RST = 20'd65536;

	typedef enum logic [1:0] {
		REG_FRICTION_COEFF    = 2'd0,
		REG_VEHICLE_MASS      = 2'd1,
		REG_REAR_WEIGHT_SHARE = 2'd2,
		REG_CURRENT_PER_FORCE = 2'd3
	} cfg_reg_t;

	// One wheel's square root in progress: remaining radicand and partial root.
	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} root_lane_t;

	typedef struct packed {
		root_lane_t left;
		root_lane_t right;
	} root_pair_t;

endpackage

FILE: src/fccl_channels.sv
// Valid/ready channel interfaces for the sensor words and the current limit words.
`timescale 1ns / 1ps
interface fccl_in_if;
	import fccl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [LOAD_W-1:0]         load_left;
	logic [LOAD_W-1:0]         load_right;
	logic signed [ACCEL_W-1:0] lat_accel;

	modport source (output valid, output load_left, output load_right, output lat_accel,
		input ready);
	modport sink (input valid, input load_left, input load_right, input lat_accel,
		output ready);
endinterface

interface fccl_out_if;
	import fccl_pkg::*;

	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] limit_left;
	logic [LIMIT_W-1:0] limit_right;

	modport source (output valid, output limit_left, output limit_right, input ready);
	modport sink (input valid, input limit_left, input limit_right, output ready);
endinterface

FILE: src/fccl_front.sv
// Front pipeline: friction forces, lateral force, their squares and the clamped difference.
`timescale 1ns / 1ps
module fccl_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [fccl_pkg::LOAD_W-1:0]       load_left,
	input  logic [fccl_pkg::LOAD_W-1:0]       load_right,
	input  logic signed [fccl_pkg::ACCEL_W-1:0] lat_accel,
	input  logic [fccl_pkg::MU_W-1:0]         friction_coeff,
	input  logic [fccl_pkg::MASS_W-1:0]       vehicle_mass,
	input  logic [fccl_pkg::SHARE_W-1:0]      rear_weight_share,
	output logic                              valid_s4,
	output fccl_pkg::root_pair_t              data_s4
);
	import fccl_pkg::*;

	localparam int unsigned MAG_W  = ACCEL_W + 1;
	localparam int unsigned M1_W   = MASS_W + MAG_W;
	localparam int unsigned FYP_W  = M1_W + SHARE_W;

	logic [MAG_W-1:0]   accel_mag;
	logic [SHARE_W-1:0] share_clamped;
	logic [FYP_W-1:0]   fy_full;
	logic [SQ_W-1:0]    f2_left;
	logic [SQ_W-1:0]    f2_right;
	logic [SQ_W-1:0]    fy2;

	logic                 valid_s1, valid_s2, valid_s3;
	logic [M1_W-1:0]      m1_s1;
	logic [FORCE_W-1:0]   f_left_s1, f_right_s1;
	logic [FORCE_W-1:0]   fy_s2;
	logic [SQ_W-1:0]      f2_left_s2, f2_right_s2;
	logic [SQ_W-1:0]      fy2_s3, f2_left_s3, f2_right_s3;

	// The most negative acceleration yields exactly 32768 in the wider magnitude.
	assign accel_mag = lat_accel[ACCEL_W-1]
		? (MAG_W'(0) - {lat_accel[ACCEL_W-1], lat_accel})
		: {1'b0, lat_accel};

	assign share_clamped = (rear_weight_share > SHARE_ONE) ? SHARE_ONE : rear_weight_share;
	assign fy_full  = FYP_W'(m1_s1) * FYP_W'(share_clamped);
	assign f2_left  = SQ_W'(f_left_s1) * SQ_W'(f_left_s1);
	assign f2_right = SQ_W'(f_right_s1) * SQ_W'(f_right_s1);
	assign fy2      = SQ_W'(fy_s2) * SQ_W'(fy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s1      <= M1_W'(vehicle_mass) * M1_W'(accel_mag);
			f_left_s1  <= FORCE_W'(friction_coeff) * FORCE_W'(load_left);
			f_right_s1 <= FORCE_W'(friction_coeff) * FORCE_W'(load_right);

			// The product stays below 2^41, so the shifted value fits the force width.
			fy_s2       <= fy_full[FY_SHIFT +: FORCE_W];
			f2_left_s2  <= f2_left;
			f2_right_s2 <= f2_right;

			fy2_s3      <= fy2;
			f2_left_s3  <= f2_left_s2;
			f2_right_s3 <= f2_right_s2;

			data_s4.left.rem   <= (f2_left_s3 > fy2_s3) ? (f2_left_s3 - fy2_s3) : '0;
			data_s4.right.rem  <= (f2_right_s3 > fy2_s3) ? (f2_right_s3 - fy2_s3) : '0;
			data_s4.left.root  <= '0;
			data_s4.right.root <= '0;
		end
	end

endmodule

FILE: src/fccl_sqrt_cell.sv
// One cell of the square root chain: settles one root bit for both wheels.
`timescale 1ns / 1ps
module fccl_sqrt_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 valid_in,
	input  fccl_pkg::root_pair_t data_in,
	output logic                 valid_q,
	output fccl_pkg::root_pair_t data_q
);
	import fccl_pkg::*;

	localparam logic [SQ_W-1:0] ROOT_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

	function automatic root_lane_t root_step(root_lane_t lane);
		logic [SQ_W-1:0] trial;
		root_lane_t      nxt;
		trial = lane.root + ROOT_BIT;
		if (lane.rem >= trial) begin
			nxt.rem  = lane.rem - trial;
			nxt.root = (lane.root >> 1) + ROOT_BIT;
		end else begin
			nxt.rem  = lane.rem;
			nxt.root = lane.root >> 1;
		end
		return nxt;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q.left  <= root_step(data_in.left);
			data_q.right <= root_step(data_in.right);
		end
	end

endmodule

FILE: src/fccl_scale.sv
// Scales both roots by the current gain and saturates them to the limit width.
`timescale 1ns / 1ps
module fccl_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          valid_in,
	input  logic [fccl_pkg::FORCE_W-1:0]  root_left,
	input  logic [fccl_pkg::FORCE_W-1:0]  root_right,
	input  logic [fccl_pkg::CPF_W-1:0]    current_per_force,
	output logic                          valid_q,
	output logic [fccl_pkg::LIMIT_W-1:0]  limit_left_q,
	output logic [fccl_pkg::LIMIT_W-1:0]  limit_right_q
);
	import fccl_pkg::*;

	localparam int unsigned PROD_W = FORCE_W + CPF_W;
	localparam int unsigned CUR_W  = PROD_W - CUR_SHIFT;

	logic [PROD_W-1:0]  prod_left, prod_right;
	logic [CUR_W-1:0]   cur_left, cur_right;
	logic [LIMIT_W-1:0] sat_left, sat_right;

	assign prod_left  = PROD_W'(root_left) * PROD_W'(current_per_force);
	assign prod_right = PROD_W'(root_right) * PROD_W'(current_per_force);
	assign cur_left   = prod_left[PROD_W-1:CUR_SHIFT];
	assign cur_right  = prod_right[PROD_W-1:CUR_SHIFT];
	assign sat_left   = (|cur_left[CUR_W-1:LIMIT_W]) ? '1 : cur_left[LIMIT_W-1:0];
	assign sat_right  = (|cur_right[CUR_W-1:LIMIT_W]) ? '1 : cur_right[LIMIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			limit_left_q  <= sat_left;
			limit_right_q <= sat_right;
		end
	end

endmodule

FILE: src/friction_circle_current_limit.sv
// Friction circle current limit: two motor current limits from wheel loads and lateral accel.
// Throughput: one word per cycle while the skid word is empty; the 32-cell square root chain halts while it is full.
// A skid word behind the output register lets one word in while a result waits.
// Reset clears all valid bits and loads the configuration registers with their reset values.
`timescale 1ns / 1ps
module friction_circle_current_limit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [fccl_pkg::CFG_W-1:0]  cfg_data,
	fccl_in_if.sink                     sensor,
	fccl_out_if.source                  limits
);
	import fccl_pkg::*;

	logic [MU_W-1:0]    friction_coeff_q;
	logic [MASS_W-1:0]  vehicle_mass_q;
	logic [SHARE_W-1:0] rear_weight_share_q;
	logic [CPF_W-1:0]   current_per_force_q;

	logic               adv;
	logic               chain_valid [0:SQRT_STEPS];
	root_pair_t         chain_data  [0:SQRT_STEPS];
	logic               p_valid;
	logic [LIMIT_W-1:0] p_left, p_right;

	logic               out_valid_q, skid_valid_q;
	logic [LIMIT_W-1:0] out_left_q, out_right_q, skid_left_q, skid_right_q;
	logic               out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			friction_coeff_q    <= FRICTION_COEFF_RST;
			vehicle_mass_q      <= VEHICLE_MASS_RST;
			rear_weight_share_q <= REAR_WEIGHT_SHARE_RST;
			current_per_force_q <= CURRENT_PER_FORCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRICTION_COEFF:    friction_coeff_q    <= cfg_data[MU_W-1:0];
				REG_VEHICLE_MASS:      vehicle_mass_q      <= cfg_data[MASS_W-1:0];
				REG_REAR_WEIGHT_SHARE: rear_weight_share_q <= cfg_data[SHARE_W-1:0];
				REG_CURRENT_PER_FORCE: current_per_force_q <= cfg_data[CPF_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together and halts only while the skid word is occupied.
	assign adv          = !skid_valid_q;
	assign sensor.ready = adv;

	fccl_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_valid          (sensor.valid),
		.load_left         (sensor.load_left),
		.load_right        (sensor.load_right),
		.lat_accel         (sensor.lat_accel),
		.friction_coeff    (friction_coeff_q),
		.vehicle_mass      (vehicle_mass_q),
		.rear_weight_share (rear_weight_share_q),
		.valid_s4          (chain_valid[0]),
		.data_s4           (chain_data[0])
	);

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
		fccl_sqrt_cell #(
			.STEP (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.valid_in (chain_valid[g]),
			.data_in  (chain_data[g]),
			.valid_q  (chain_valid[g+1]),
			.data_q   (chain_data[g+1])
		);
	end

	fccl_scale u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.valid_in          (chain_valid[SQRT_STEPS]),
		.root_left         (chain_data[SQRT_STEPS].left.root[FORCE_W-1:0]),
		.root_right        (chain_data[SQRT_STEPS].right.root[FORCE_W-1:0]),
		.current_per_force (current_per_force_q),
		.valid_q           (p_valid),
		.limit_left_q      (p_left),
		.limit_right_q     (p_right)
	);

	assign out_free = !out_valid_q || limits.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || p_valid;
			skid_valid_q <= 1'b0;
		end else if (p_valid && adv) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_left_q  <= skid_valid_q ? skid_left_q : p_left;
			out_right_q <= skid_valid_q ? skid_right_q : p_right;
		end else if (p_valid && adv) begin
			skid_left_q  <= p_left;
			skid_right_q <= p_right;
		end
	end

	assign limits.valid       = out_valid_q;
	assign limits.limit_left  = out_left_q;
	assign limits.limit_right = out_right_q;

endmodule

FILE: src/fccl_checker.sv
// Port-level checks of the friction circle current limit, bound to the top level.
`timescale 1ns / 1ps
`include "friction_circle_current_limit_defines.svh"
module fccl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [fccl_pkg::LIMIT_W-1:0] limit_left,
	input logic [fccl_pkg::LIMIT_W-1:0] limit_right
);

	`FCCL_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`FCCL_ASSERT_NEXT(a_out_word_held, out_valid && !out_ready, $stable(limit_left) && $stable(limit_right), "result word changed while stalled")
	`FCCL_ASSERT_NOW(a_busy_needs_result, !in_ready, out_valid, "input blocked with no result waiting")
	`FCCL_ASSERT_NEXT(a_ready_returns, !in_ready && out_valid && out_ready, in_ready, "input still blocked after a result was taken")

endmodule

bind friction_circle_current_limit fccl_checker u_fccl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (sensor.ready),
	.out_valid   (limits.valid),
	.out_ready   (limits.ready),
	.limit_left  (limits.limit_left),
	.limit_right (limits.limit_right)
);

FILE: bench/testbench.sv
// Self-checking bench for the friction circle current limit, with a scoreboard class.
`timescale 1ns / 1ps
module testbench;
	import fccl_pkg::*;

	typedef struct packed {
		logic [LOAD_W-1:0]  load_left;
		logic [LOAD_W-1:0]  load_right;
		logic [ACCEL_W-1:0] lat_accel;
	} sensor_word_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit_left;
		logic [LIMIT_W-1:0] limit_right;
	} limit_pair_t;

	class limit_scoreboard;
		bit [MU_W-1:0]    mu;
		bit [MASS_W-1:0]  mass;
		bit [SHARE_W-1:0] share;
		bit [CPF_W-1:0]   gain;
		limit_pair_t      pending_limits[$];
		int unsigned      mismatches;
		int unsigned      words_seen;
		int unsigned      zero_limits;
		int unsigned      saturated_limits;

		function new();
			mu = FRICTION_COEFF_RST;
			mass = VEHICLE_MASS_RST;
			share = REAR_WEIGHT_SHARE_RST;
			gain = CURRENT_PER_FORCE_RST;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [CFG_W-1:0] data);
			case (idx)
				REG_FRICTION_COEFF: mu = data[MU_W-1:0];
				REG_VEHICLE_MASS: mass = data[MASS_W-1:0];
				REG_REAR_WEIGHT_SHARE: share = data[SHARE_W-1:0];
				REG_CURRENT_PER_FORCE: gain = data[CPF_W-1:0];
				default: ;
			endcase
		endfunction

		// Builds the root one bit at a time from the top; trial squares stay below 2^64.
		function bit [63:0] floor_root(bit [63:0] x);
			bit [63:0] root;
			bit [63:0] trial;
			root = 0;
			for (int b = 31; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= x)
					root = trial;
			end
			return root;
		endfunction

		function bit [LIMIT_W-1:0] wheel_current(bit [LOAD_W-1:0] load, bit [63:0] lat_force);
			bit [63:0] grip;
			bit [63:0] grip_sq;
			bit [63:0] lat_sq;
			bit [63:0] spare;
			bit [63:0] cur;
			grip = 64'(mu) * 64'(load);
			grip_sq = grip * grip;
			lat_sq = lat_force * lat_force;
			spare = (grip_sq > lat_sq) ? grip_sq - lat_sq : 64'd0;
			cur = (floor_root(spare) * 64'(gain)) >> CUR_SHIFT;
			return (cur > 64'd65535) ? 16'hFFFF : cur[LIMIT_W-1:0];
		endfunction

		function limit_pair_t predict_limits(sensor_word_t w);
			limit_pair_t p;
			bit [16:0]   mag;
			bit [16:0]   eff_share;
			bit [63:0]   lat_force;
			mag = w.lat_accel[ACCEL_W-1] ? 17'h10000 - {1'b0, w.lat_accel} : {1'b0, w.lat_accel};
			eff_share = (share > SHARE_ONE) ? SHARE_ONE : share;
			lat_force = (64'(mass) * 64'(mag) * 64'(eff_share)) >> FY_SHIFT;
			p.limit_left = wheel_current(w.load_left, lat_force);
			p.limit_right = wheel_current(w.load_right, lat_force);
			return p;
		endfunction

		function void note_sample(sensor_word_t w);
			limit_pair_t p;
			p = predict_limits(w);
			words_seen++;
			zero_limits += 32'(p.limit_left == 0) + 32'(p.limit_right == 0);
			saturated_limits += 32'(p.limit_left == 16'hFFFF) + 32'(p.limit_right == 16'hFFFF);
			pending_limits.push_back(p);
		endfunction

		function void check_limits(limit_pair_t got);
			limit_pair_t want;
			if (pending_limits.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected limit word, expected none, got %0d/%0d",
					$time, got.limit_left, got.limit_right);
				return;
			end
			want = pending_limits.pop_front();
			if (got.limit_left !== want.limit_left) begin
				mismatches++;
				$display("%0t: limit_left mismatch, expected %0d, got %0d",
					$time, want.limit_left, got.limit_left);
			end
			if (got.limit_right !== want.limit_right) begin
				mismatches++;
				$display("%0t: limit_right mismatch, expected %0d, got %0d",
					$time, want.limit_right, got.limit_right);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	int unsigned         send_idle;
	int unsigned         recv_idle;
	int unsigned         settings_run;
	limit_scoreboard     board = new();

	fccl_in_if  sensor_ch();
	fccl_out_if limit_ch();

	friction_circle_current_limit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sensor(sensor_ch),
		.limits(limit_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: check each accepted word, then pick the next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && limit_ch.valid && limit_ch.ready)
			board.check_limits({limit_ch.limit_left, limit_ch.limit_right});
		limit_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_sample(sensor_word_t w);
		while ($urandom_range(99) < send_idle) begin
			sensor_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.load_left <= w.load_left;
		sensor_ch.load_right <= w.load_right;
		sensor_ch.lat_accel <= w.lat_accel;
		do
			@(posedge clk);
		while (!sensor_ch.ready);
		board.note_sample(w);
	endtask

	task automatic wait_drained();
		sensor_ch.valid <= 1'b0;
		while (board.pending_limits.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_regs(bit [CFG_W-1:0] mu, bit [CFG_W-1:0] mass,
			bit [CFG_W-1:0] share, bit [CFG_W-1:0] gain);
		bit [CFG_W-1:0] vals[4];
		cfg_reg_t       idx;
		vals = '{mu, mass, share, gain};
		idx = REG_FRICTION_COEFF;
		cfg_we <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= idx;
			cfg_data <= vals[i];
			@(posedge clk);
			board.write_reg(idx, vals[i]);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [LOAD_W-1:0] pick_load();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return LOAD_W'($urandom_range(65535));
		endcase
	endfunction

	// Half of the accelerations aim near the edge of the friction circle, so that both the
	// clamp at zero and the square root of small differences get exercised.
	function automatic logic [ACCEL_W-1:0] pick_accel(logic [LOAD_W-1:0] load);
		bit [63:0] target;
		bit [63:0] denom;
		bit [63:0] mag;
		bit        neg;
		neg = 1'($urandom_range(1));
		denom = 64'(board.mass) * 64'((board.share > SHARE_ONE) ? SHARE_ONE : board.share);
		case ($urandom_range(3))
			0: return ACCEL_W'($urandom());
			1: mag = 64'($urandom_range(511));
			default: begin
				if (denom == 0)
					return ACCEL_W'($urandom());
				target = 64'(board.mu) * 64'(load) * 64'($urandom_range(80, 120)) / 64'd100;
				mag = (target << FY_SHIFT) / denom;
			end
		endcase
		if (mag > 64'd32768)
			mag = 64'd32768;
		if (!neg && mag == 64'd32768)
			mag = 64'd32767;
		return neg ? ACCEL_W'(64'd0 - mag) : ACCEL_W'(mag);
	endfunction

	task automatic send_random(int unsigned count);
		sensor_word_t w;
		repeat (count) begin
			w.load_left = pick_load();
			w.load_right = pick_load();
			w.lat_accel = pick_accel($urandom_range(1) ? w.load_left : w.load_right);
			send_sample(w);
		end
	endtask

	initial begin
		sensor_word_t directed[$];
		sensor_ch.valid <= 1'b0;
		sensor_ch.load_left <= '0;
		sensor_ch.load_right <= '0;
		sensor_ch.lat_accel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FRICTION_COEFF;
		cfg_data <= '0;
		send_idle = 26;
		recv_idle = 73;
		settings_run = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With reset settings the lateral force is 19200 per accel step against
		// 16384 per load step, so a load of 1000 crosses the circle at 853/854.
		directed = '{
			'{16'd0, 16'd0, 16'd0},
			'{16'hFFFF, 16'hFFFF, 16'd0},
			'{16'hFFFF, 16'd0, 16'h8000},
			'{16'd0, 16'hFFFF, 16'h7FFF},
			'{16'hFFFF, 16'hFFFF, 16'h8000},
			'{16'hFFFF, 16'hFFFF, 16'h7FFF},
			'{16'd1, 16'd1, 16'd1},
			'{16'd1000, 16'd1000, 16'd853},
			'{16'd1000, 16'd1000, 16'd854},
			'{16'd1000, 16'd999, -16'sd853},
			'{16'h5555, 16'hAAAA, 16'h5555},
			'{16'hAAAA, 16'h5555, 16'hAAAA},
			'{16'd4096, 16'd8192, 16'hFFFF},
			'{16'd40000, 16'd100, -16'sd200},
			'{16'd256, 16'd65535, 16'd1},
			'{16'd300, 16'd60000, 16'd30000},
			'{16'd2, 16'd3, 16'h8001},
			'{16'd65535, 16'd1, 16'd255},
			'{16'd12345, 16'd54321, -16'sd4321},
			'{16'd32768, 16'd32767, 16'd16384}
		};
		foreach (directed[i])
			send_sample(directed[i]);
		send_random(50);
		wait_drained();

		for (int s = 1; s < 9; s++) begin
			if (s == 3) begin
				send_idle = 73;
				recv_idle = 26;
			end else if (s == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (s)
				1: write_regs(20'd65535, 20'd1023, 20'd65536, 20'hFFFFF);
				2: write_regs(20'd0, 20'd0, 20'd0, 20'd0);
				3: write_regs(20'd16384, 20'd1023, 20'h1FFFF, 20'd65536);
				4: write_regs(20'd65535, 20'd300, 20'd65536, 20'd0);
				5: write_regs(20'd20000, 20'd500, 20'd40000, 20'd4096);
				default: write_regs(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(1023)),
					CFG_W'($urandom_range(131071)), CFG_W'($urandom_range(1048575)));
			endcase
			send_random(50);
			wait_drained();
		end

		// Any stray word would show up within the pipeline depth.
		repeat (40) @(posedge clk);
		$display("Checked %0d sensor words over %0d register settings, with both sides stalling.",
			board.words_seen, settings_run);
		$display("Expected limits included %0d zeros and %0d saturated values.",
			board.zero_limits, board.saturated_limits);
		if (board.mismatches == 0 && board.pending_limits.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout waiting for the current limit block.");
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: friction_circle_current_limit.f
+incdir+src
src/fccl_pkg.sv
src/fccl_channels.sv
src/fccl_front.sv
src/fccl_sqrt_cell.sv
src/fccl_scale.sv
src/friction_circle_current_limit.sv
src/fccl_checker.sv
bench/testbench.sv
